>>> sv/bdab_pkg.sv
// shared types, constants and arithmetic helpers for the backlight dimmer
// no dependencies
package bdab_pkg;

  localparam logic [31:0] UpdateIntervalMs = 32'd100;
  localparam logic [15:0] MsPerMinute      = 16'd60000;
  localparam logic [7:0]  LevelFull        = 8'd200;
  localparam logic [7:0]  CodeAutoOff      = 8'd202;
  localparam logic [7:0]  CodeAutoOn       = 8'd204;
  localparam logic [7:0]  CodeToggle       = 8'd255;
  localparam logic signed [8:0] StepDeadband = 9'sd3;

  typedef enum logic [1:0] {
    CfgStartupOn     = 2'd0,
    CfgAutoOffMin    = 2'd1,
    CfgInitialAuto   = 2'd2,
    CfgSensorPresent = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic        command;
    logic [7:0]  set_code;
    logic        has_key;
    logic [7:0]  key_number;
    logic [31:0] now_ms;
    logic [9:0]  light_sample;
  } item_t;

  typedef struct packed {
    logic [7:0] level;
    logic       pwm_update;
    logic       auto_mode;
  } result_t;

  typedef struct packed {
    logic        startup_on;
    logic        sensor_present;
    logic [23:0] off_limit_ms;
    logic        auto_load;
    logic        auto_value;
  } cfg_t;

  // floor(s * 200 / 255)
  function automatic logic [7:0] light_to_level(input logic [7:0] s);
    logic [15:0] p;
    logic [15:0] t;
    begin
      p = 16'(s) * 16'd200;
      t = p + (p >> 8) + 16'd1;
      return t[15:8];
    end
  endfunction

  // floor(l * 255 / 200) = l + floor(floor(l * 11 / 8) / 5)
  function automatic logic [7:0] level_to_duty(input logic [7:0] l);
    logic [11:0] t;
    logic [9:0]  u;
    logic [19:0] v;
    logic [8:0]  d;
    begin
      t = 12'(l) * 12'd11;
      u = t[11:3] + 10'd0;
      v = 20'(u) * 20'd205;
      d = 9'(l) + 9'(v[19:10]);
      return d[7:0];
    end
  endfunction

  // floor(d / 50) for d in 0..255
  function automatic logic [2:0] div50(input logic [7:0] d);
    logic [13:0] p;
    begin
      p = 14'(d) * 14'd41;
      return p[13:11];
    end
  endfunction

endpackage

>>> sv/bdab_in_if.sv
// input channel: set and tick beats
// depends on nothing
interface bdab_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  set_code;
  logic        has_key;
  logic [7:0]  key_number;
  logic [31:0] now_ms;
  logic [9:0]  light_sample;

  modport source (output valid, command, set_code, has_key, key_number, now_ms,
                  light_sample, input ready);
  modport sink (input valid, command, set_code, has_key, key_number, now_ms,
                light_sample, output ready);
endinterface

>>> sv/bdab_out_if.sv
// output channel: level and duty result beats
// depends on nothing
interface bdab_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] level;
  logic [7:0] pwm_duty;
  logic       pwm_update;
  logic       auto_mode;

  modport source (output valid, level, pwm_duty, pwm_update, auto_mode, input ready);
  modport sink (input valid, level, pwm_duty, pwm_update, auto_mode, output ready);
endinterface

>>> sv/backlight_dimmer_auto_brightness_unit.sv
// Backlight dimmer with automatic brightness. Each accepted beat, set command or
// time tick, yields one result beat through the input and result registers; a new
// beat is taken every cycle unless the result channel stalls, and results back up
// through them. The rate is set by the combinational state update between the two.
// Configuration writes take effect in the next cycle and must occur while idle.
// top level: input register, dimmer state update, result register, config regs
// depends on bdab_pkg, bdab_in_if, bdab_out_if, bdab_core
module backlight_dimmer_auto_brightness_unit import bdab_pkg::*; #(
  parameter logic [31:0] IntervalMs = UpdateIntervalMs
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  bdab_in_if.sink    in_if,
  bdab_out_if.source out_if
);

  logic    in_vld_q;
  item_t   in_item_q;
  logic    out_vld_q;
  result_t out_res_q;
  logic    advance;
  result_t core_res;

  logic        startup_q;
  logic        sensor_q;
  logic [23:0] off_limit_q;
  cfg_t        cfg;
  cfg_idx_e    cfg_idx;

  assign cfg_idx = cfg_idx_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      startup_q   <= 1'b0;
      sensor_q    <= 1'b1;
      off_limit_q <= 24'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx)
        CfgStartupOn:     startup_q   <= cfg_wdata_i[0];
        CfgAutoOffMin:    off_limit_q <= 24'(cfg_wdata_i) * 24'(MsPerMinute);
        CfgInitialAuto:   ;
        CfgSensorPresent: sensor_q    <= cfg_wdata_i[0];
        default:          ;
      endcase
    end
  end

  assign cfg.startup_on     = startup_q;
  assign cfg.sensor_present = sensor_q;
  assign cfg.off_limit_ms   = off_limit_q;
  assign cfg.auto_load      = cfg_we_i && (cfg_idx == CfgInitialAuto);
  assign cfg.auto_value     = cfg_wdata_i[0];

  assign advance     = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      in_item_q.command      <= in_if.command;
      in_item_q.set_code     <= in_if.set_code;
      in_item_q.has_key      <= in_if.has_key;
      in_item_q.key_number   <= in_if.key_number;
      in_item_q.now_ms       <= in_if.now_ms;
      in_item_q.light_sample <= in_if.light_sample;
    end
  end

  bdab_core #(
    .IntervalMs (IntervalMs)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (advance),
    .item_i (in_item_q),
    .res_o  (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign out_if.valid      = out_vld_q;
  assign out_if.level      = out_res_q.level;
  assign out_if.pwm_duty   = level_to_duty(out_res_q.level);
  assign out_if.pwm_update = out_res_q.pwm_update;
  assign out_if.auto_mode  = out_res_q.auto_mode;

endmodule

>>> sv/bdab_core.sv
// dimmer state and per-beat update logic
// depends on bdab_pkg
module bdab_core import bdab_pkg::*; #(
  parameter logic [31:0] IntervalMs = UpdateIntervalMs
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    step_i,
  input  item_t   item_i,
  output result_t res_o
);

  logic [7:0]  level_q, level_d;
  logic        auto_q, auto_d;
  logic [7:0]  last_key_q, last_key_d;
  logic        wake_q, wake_d;
  logic        init_q, init_d;
  logic [31:0] last_upd_q, last_upd_d;
  logic [31:0] pwr_q, pwr_d;
  logic [7:0]  smooth_q, smooth_d;

  logic [7:0]  sample_hi;
  logic signed [8:0] diff;
  logic [3:0]  base;
  logic [3:0]  inc_up, inc_dn;
  logic [8:0]  sum_up;
  logic [7:0]  smooth_step;
  logic        refresh;
  logic [31:0] pwr_eff;
  logic [31:0] on_time;
  logic [7:0]  lvl_tick;
  logic        update;

  assign sample_hi = item_i.light_sample[9:2];
  assign diff      = $signed({1'b0, sample_hi}) - $signed({1'b0, smooth_q});
  assign base      = 4'd1 + {1'b0, level_q[7:5]};
  assign inc_up    = base + {1'b0, div50(sample_hi - smooth_q)};
  assign inc_dn    = base + {1'b0, div50(smooth_q - sample_hi)};
  assign sum_up    = {1'b0, smooth_q} + {5'b0, inc_up};

  always_comb begin
    smooth_step = smooth_q;
    if (diff > StepDeadband) begin
      smooth_step = sum_up[8] ? 8'hff : sum_up[7:0];
    end else if (diff < -StepDeadband) begin
      smooth_step = (smooth_q < {4'b0, inc_dn}) ? 8'd0 : smooth_q - {4'b0, inc_dn};
    end
  end

  assign refresh = ((item_i.now_ms - last_upd_q) > IntervalMs) || wake_q;
  assign pwr_eff = wake_q ? item_i.now_ms : pwr_q;
  assign on_time = item_i.now_ms - pwr_eff;

  always_comb begin
    lvl_tick = level_q;
    if (auto_q && cfg_i.sensor_present) begin
      lvl_tick = light_to_level(smooth_step);
    end
    if ((cfg_i.off_limit_ms != 24'd0) && (on_time >= {8'b0, cfg_i.off_limit_ms})) begin
      lvl_tick = 8'd0;
    end
  end

  always_comb begin
    level_d    = level_q;
    auto_d     = auto_q;
    last_key_d = last_key_q;
    wake_d     = wake_q;
    init_d     = init_q;
    last_upd_d = last_upd_q;
    pwr_d      = pwr_q;
    smooth_d   = smooth_q;
    update     = 1'b0;
    if (!item_i.command) begin
      if (!(item_i.has_key && (last_key_q == item_i.key_number))) begin
        if (item_i.has_key) begin
          last_key_d = item_i.key_number;
        end
        wake_d = 1'b1;
        if (item_i.set_code > LevelFull) begin
          priority if (item_i.set_code == CodeAutoOff) begin
            auto_d = 1'b0;
          end else if (item_i.set_code == CodeAutoOn) begin
            auto_d = 1'b1;
          end else if ((item_i.set_code == CodeToggle) && !auto_q) begin
            level_d = (level_q != 8'd0) ? 8'd0 : LevelFull;
          end else begin
            // other codes only wake the display
            level_d = level_q;
          end
        end else begin
          level_d = item_i.set_code;
          auto_d  = 1'b0;
        end
      end
    end else if (!init_q) begin
      if (cfg_i.startup_on) begin
        level_d = LevelFull;
      end
      init_d = 1'b1;
    end else if (refresh) begin
      last_upd_d = item_i.now_ms;
      wake_d     = 1'b0;
      pwr_d      = pwr_eff;
      if (auto_q && cfg_i.sensor_present) begin
        smooth_d = smooth_step;
      end
      level_d = lvl_tick;
      update  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q    <= 8'd0;
      auto_q     <= 1'b0;
      last_key_q <= 8'd0;
      wake_q     <= 1'b1;
      init_q     <= 1'b0;
      last_upd_q <= 32'd0;
      pwr_q      <= 32'd0;
      smooth_q   <= 8'd0;
    end else begin
      if (cfg_i.auto_load) begin
        auto_q <= cfg_i.auto_value;
      end else if (step_i) begin
        auto_q <= auto_d;
      end
      if (step_i) begin
        level_q    <= level_d;
        last_key_q <= last_key_d;
        wake_q     <= wake_d;
        init_q     <= init_d;
        last_upd_q <= last_upd_d;
        pwr_q      <= pwr_d;
        smooth_q   <= smooth_d;
      end
    end
  end

  assign res_o.level      = level_d;
  assign res_o.pwm_update = update;
  assign res_o.auto_mode  = auto_d;

endmodule

>>> sv/bdab_chk.sv
// port-level checks on the dimmer result channel, bound to the top level
// depends on backlight_dimmer_auto_brightness_unit
module bdab_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_level_i,
  input logic [7:0] out_duty_i,
  input logic       out_update_i,
  input logic       out_auto_i
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_level_i)
      && $stable(out_duty_i) && $stable(out_update_i) && $stable(out_auto_i))
    else $error("result beat changed while stalled");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_level_i <= 8'd200)
    else $error("level above full scale");

  a_duty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((out_level_i == 8'd0) == (out_duty_i == 8'd0)))
    else $error("duty and level disagree on off");

  a_duty_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((out_level_i == 8'd200) == (out_duty_i == 8'd255)))
    else $error("duty and level disagree on full on");

endmodule

bind backlight_dimmer_auto_brightness_unit bdab_chk u_bdab_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .out_level_i  (out_if.level),
  .out_duty_i   (out_if.pwm_duty),
  .out_update_i (out_if.pwm_update),
  .out_auto_i   (out_if.auto_mode)
);

>>> sim/tb.sv
// self-checking bench for backlight_dimmer_auto_brightness_unit: directed table, then
// random set/tick beats under several register settings, checked against an in-bench predictor
// depends on bdab_pkg, bdab_in_if, bdab_out_if and the dimmer top level
`timescale 1ns / 100ps

module tb;
  import bdab_pkg::*;

  localparam int          QuietLimit   = 5000;
  localparam int          ItemsPerRun  = 230;
  localparam int          NumRuns      = 6;
  localparam int          NumRows      = 24;
  localparam logic [7:0]  DutyFull     = 8'd255;
  localparam logic [31:0] MsPerMin     = 32'd60000;

  typedef struct packed {
    logic [7:0] level;
    logic [7:0] duty;
    logic       upd;
    logic       am;
  } dim_out_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  code;
    logic        keyed;
    logic [7:0]  key;
    logic [31:0] now;
    logic [9:0]  sample;
    logic        typed;
    logic [7:0]  lvl;
    logic [7:0]  duty;
    logic        upd;
    logic        am;
  } row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_wdata_i;

  bdab_in_if  in_ch ();
  bdab_out_if out_ch ();

  backlight_dimmer_auto_brightness_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // predictor copy of the registers
  logic        cfg_startup;
  logic [7:0]  cfg_off_min;
  logic        cfg_sensor;

  // predictor copy of the dimmer state
  logic [7:0]  lvl;
  logic        auto_on;
  logic [7:0]  prev_key;
  logic        wake;
  logic        started;
  logic [31:0] last_upd;
  logic [31:0] wake_ms;
  logic [7:0]  bright;

  dim_out_t dim_out_q[$];
  dim_out_t want_res;

  int mismatches   = 0;
  int items_sent   = 0;
  int ticks_sent   = 0;
  int refreshes    = 0;
  int results_seen = 0;
  int cfg_writes   = 0;
  int quiet        = 0;
  int stall_left   = 0;
  bit no_idle      = 1'b0;

  // random stimulus state
  logic [31:0] sim_now;
  logic [7:0]  light_target;
  logic [7:0]  sent_key;
  int          tick_share;

  row_t dir_rows [NumRows] = '{
    '{1'b1, 8'd0,        1'b0, 8'd0,   32'd0,         10'd0,    1'b1, LevelFull, DutyFull, 1'b0, 1'b0},
    '{1'b1, 8'd0,        1'b0, 8'd0,   32'd0,         10'd1023, 1'b1, LevelFull, DutyFull, 1'b1, 1'b0},
    '{1'b1, 8'd0,        1'b0, 8'd0,   32'd50,        10'd0,    1'b1, LevelFull, DutyFull, 1'b0, 1'b0},
    '{1'b1, 8'd0,        1'b0, 8'd0,   32'd100,       10'd1023, 1'b1, LevelFull, DutyFull, 1'b0, 1'b0},
    '{1'b1, 8'd0,        1'b0, 8'd0,   32'd101,       10'd0,    1'b1, LevelFull, DutyFull, 1'b1, 1'b0},
    '{1'b0, 8'd0,        1'b0, 8'd0,   32'd0,         10'd0,    1'b1, 8'd0,      8'd0,     1'b0, 1'b0},
    '{1'b0, CodeToggle,  1'b1, 8'd0,   32'd0,         10'd0,    1'b1, 8'd0,      8'd0,     1'b0, 1'b0},
    '{1'b0, CodeToggle,  1'b1, 8'd255, 32'd0,         10'd0,    1'b1, LevelFull, DutyFull, 1'b0, 1'b0},
    '{1'b0, CodeToggle,  1'b1, 8'd255, 32'd0,         10'd0,    1'b1, LevelFull, DutyFull, 1'b0, 1'b0},
    '{1'b0, CodeToggle,  1'b0, 8'd0,   32'd0,         10'd0,    1'b1, 8'd0,      8'd0,     1'b0, 1'b0},
    '{1'b0, LevelFull,   1'b1, 8'd1,   32'd0,         10'd0,    1'b1, LevelFull, DutyFull, 1'b0, 1'b0},
    '{1'b0, CodeAutoOn,  1'b1, 8'd2,   32'd0,         10'd0,    1'b1, LevelFull, DutyFull, 1'b0, 1'b1},
    '{1'b0, CodeToggle,  1'b1, 8'd3,   32'd0,         10'd0,    1'b1, LevelFull, DutyFull, 1'b0, 1'b1},
    '{1'b1, 8'd0,        1'b0, 8'd0,   32'd150,       10'd1023, 1'b0, 8'd0,      8'd0,     1'b0, 1'b0},
    '{1'b1, 8'd0,        1'b0, 8'd0,   32'd251,       10'd1023, 1'b0, 8'd0,      8'd0,     1'b0, 1'b0},
    '{1'b1, 8'd0,        1'b0, 8'd0,   32'd351,       10'd1023, 1'b0, 8'd0,      8'd0,     1'b0, 1'b0},
    '{1'b0, 8'd201,      1'b1, 8'd4,   32'd0,         10'd0,    1'b0, 8'd0,      8'd0,     1'b0, 1'b0},
    '{1'b0, 8'd203,      1'b0, 8'd0,   32'd0,         10'd0,    1'b0, 8'd0,      8'd0,     1'b0, 1'b0},
    '{1'b1, 8'd0,        1'b0, 8'd0,   32'd352,       10'd0,    1'b0, 8'd0,      8'd0,     1'b0, 1'b0},
    '{1'b0, CodeAutoOff, 1'b1, 8'd5,   32'd0,         10'd0,    1'b0, 8'd0,      8'd0,     1'b0, 1'b0},
    '{1'b0, 8'd254,      1'b1, 8'd6,   32'd0,         10'd0,    1'b0, 8'd0,      8'd0,     1'b0, 1'b0},
    '{1'b1, 8'd0,        1'b0, 8'd0,   32'hFFFF_FFF0, 10'd512,  1'b0, 8'd0,      8'd0,     1'b0, 1'b0},
    '{1'b1, 8'd0,        1'b0, 8'd0,   32'h0000_0010, 10'd700,  1'b0, 8'd0,      8'd0,     1'b0, 1'b0},
    '{1'b1, 8'd0,        1'b0, 8'd0,   32'h0000_0061, 10'd300,  1'b0, 8'd0,      8'd0,     1'b0, 1'b0}
  };

  logic [7:0] run_cfg [NumRuns][4] = '{
    '{8'd0, 8'd0,   8'd1, 8'd1},
    '{8'd1, 8'd1,   8'd0, 8'd1},
    '{8'd0, 8'd255, 8'd1, 8'd1},
    '{8'd1, 8'd0,   8'd1, 8'd0},
    '{8'd0, 8'd0,   8'd0, 8'd0},
    '{8'd0, 8'd3,   8'd1, 8'd1}
  };

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s, got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic dimmer_step(input item_t it, output dim_out_t res);
    int  diff;
    int  b;
    int  base;
    logic refresh;
    refresh = 1'b0;
    if (!it.command) begin
      if (!(it.has_key && it.key_number == prev_key)) begin
        if (it.has_key) prev_key = it.key_number;
        wake = 1'b1;
        if (it.set_code > LevelFull) begin
          if (it.set_code == CodeAutoOff) auto_on = 1'b0;
          else if (it.set_code == CodeAutoOn) auto_on = 1'b1;
          else if (it.set_code == CodeToggle && !auto_on) lvl = (lvl != 8'd0) ? 8'd0 : LevelFull;
        end else begin
          lvl = it.set_code;
          auto_on = 1'b0;
        end
      end
    end else if (!started) begin
      if (cfg_startup) lvl = LevelFull;
      started = 1'b1;
    end else if ((it.now_ms - last_upd) > UpdateIntervalMs || wake) begin
      refresh = 1'b1;
      refreshes++;
      last_upd = it.now_ms;
      if (wake) begin
        wake = 1'b0;
        wake_ms = it.now_ms;
      end
      if (auto_on && cfg_sensor) begin
        diff = int'(it.light_sample >> 2) - int'(bright);
        b = int'(bright);
        base = 1 + int'(lvl) / 32;
        if (diff > 3) begin
          b = b + base + diff / 50;
          if (b > 255) b = 255;
        end else if (diff < -3) begin
          b = b - base - (-diff) / 50;
          if (b < 0) b = 0;
        end
        bright = 8'(b);
        lvl = 8'((b * 200) / 255);
      end
      if (cfg_off_min != 8'd0 && (it.now_ms - wake_ms) >= 32'(cfg_off_min) * MsPerMin) lvl = 8'd0;
    end
    res.level = lvl;
    res.duty  = 8'((int'(lvl) * 255) / 200);
    res.upd   = refresh;
    res.am    = auto_on;
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_writes++;
    case (idx)
      CfgStartupOn:     cfg_startup = val[0];
      CfgAutoOffMin:    cfg_off_min = val;
      CfgInitialAuto:   auto_on     = val[0];
      CfgSensorPresent: cfg_sensor  = val[0];
      default: ;
    endcase
  endtask

  task automatic send_item(input item_t it, input bit typed, input dim_out_t typed_res);
    int       gap;
    dim_out_t res;
    gap = no_idle ? 0 : gap_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= it.command;
    in_ch.set_code     <= it.set_code;
    in_ch.has_key      <= it.has_key;
    in_ch.key_number   <= it.key_number;
    in_ch.now_ms       <= it.now_ms;
    in_ch.light_sample <= it.light_sample;
    do @(posedge clk_i); while (!in_ch.ready);
    dimmer_step(it, res);
    dim_out_q.push_back(typed ? typed_res : res);
    items_sent++;
    if (it.command) ticks_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (dim_out_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic next_random_item(output item_t it);
    int r;
    it.command      = ($urandom_range(0, 99) < tick_share);
    it.set_code     = 8'($urandom);
    it.has_key      = 1'($urandom);
    it.key_number   = 8'($urandom);
    it.now_ms       = $urandom;
    it.light_sample = 10'($urandom);
    if (it.command) begin
      r = $urandom_range(0, 99);
      if (r < 55) sim_now = sim_now + $urandom_range(0, 150);
      else if (r < 80) sim_now = sim_now + $urandom_range(90, 110);
      else if (r < 92) sim_now = sim_now + $urandom_range(150, 5000);
      else if (r < 98) sim_now = sim_now + $urandom_range(0, 20000000);
      else sim_now = $urandom;
      it.now_ms = sim_now;
      if ($urandom_range(0, 19) == 0)
        light_target = ($urandom_range(0, 2) == 0) ? {8{1'($urandom)}} : 8'($urandom);
      if ($urandom_range(0, 4) != 0)
        it.light_sample = {light_target, 2'($urandom)};
    end else begin
      r = $urandom_range(0, 99);
      if (r < 35) it.set_code = 8'($urandom_range(0, 200));
      else if (r < 50) it.set_code = CodeAutoOff;
      else if (r < 68) it.set_code = CodeAutoOn;
      else if (r < 85) it.set_code = CodeToggle;
      else begin
        it.set_code = 8'($urandom_range(201, 254));
        if (it.set_code == CodeAutoOff || it.set_code == CodeAutoOn)
          it.set_code = it.set_code + 8'd1;
      end
      if (it.has_key) begin
        r = $urandom_range(0, 99);
        if (r < 65) it.key_number = sent_key + 8'd1;
        else if (r < 85) it.key_number = sent_key;
        sent_key = it.key_number;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (stall_left != 0) stall_left--;
      else if (!no_idle && $urandom_range(0, 4) == 0) stall_left = gap_len();
      out_ch.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (dim_out_q.size() == 0) begin
        report_mismatch("result beat with nothing pending, level", out_ch.level, 0);
      end else begin
        want_res = dim_out_q.pop_front();
        if (out_ch.level !== want_res.level)
          report_mismatch("level", out_ch.level, want_res.level);
        if (out_ch.pwm_duty !== want_res.duty)
          report_mismatch("pwm_duty", out_ch.pwm_duty, want_res.duty);
        if (out_ch.pwm_update !== want_res.upd)
          report_mismatch("pwm_update", out_ch.pwm_update, want_res.upd);
        if (out_ch.auto_mode !== want_res.am)
          report_mismatch("auto_mode", out_ch.auto_mode, want_res.am);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= QuietLimit) begin
        $display("watchdog: no beat moved in %0d cycles, %0d results pending", quiet,
                 dim_out_q.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    item_t    it;
    dim_out_t typed_res;
    logic [7:0] v;
    rst_ni             = 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CfgStartupOn;
    cfg_wdata_i       <= 8'd0;
    in_ch.valid       <= 1'b0;
    in_ch.command     <= 1'b0;
    in_ch.set_code    <= 8'd0;
    in_ch.has_key     <= 1'b0;
    in_ch.key_number  <= 8'd0;
    in_ch.now_ms      <= 32'd0;
    in_ch.light_sample <= 10'd0;
    cfg_startup = 1'b0;
    cfg_off_min = 8'd0;
    cfg_sensor  = 1'b1;
    lvl         = 8'd0;
    auto_on     = 1'b0;
    prev_key    = 8'd0;
    wake        = 1'b1;
    started     = 1'b0;
    last_upd    = 32'd0;
    wake_ms     = 32'd0;
    bright      = 8'd0;
    sim_now      = 32'd1000;
    light_target = 8'd128;
    sent_key     = 8'd6;
    tick_share   = 60;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // startup level only matters before the very first tick
    cfg_write(CfgStartupOn, 8'h01);
    foreach (dir_rows[i]) begin
      it.command      = dir_rows[i].cmd;
      it.set_code     = dir_rows[i].code;
      it.has_key      = dir_rows[i].keyed;
      it.key_number   = dir_rows[i].key;
      it.now_ms       = dir_rows[i].now;
      it.light_sample = dir_rows[i].sample;
      typed_res.level = dir_rows[i].lvl;
      typed_res.duty  = dir_rows[i].duty;
      typed_res.upd   = dir_rows[i].upd;
      typed_res.am    = dir_rows[i].am;
      send_item(it, dir_rows[i].typed, typed_res);
    end
    drain();

    for (int p = 0; p < NumRuns; p++) begin
      if (p == 4) begin
        run_cfg[p][0] = 8'($urandom_range(0, 1));
        run_cfg[p][1] = 8'($urandom_range(1, 20));
        run_cfg[p][2] = 8'($urandom_range(0, 1));
        run_cfg[p][3] = 8'($urandom_range(0, 1));
      end
      // junk in the upper bits of the one-bit registers
      v = {7'($urandom), run_cfg[p][0][0]};
      cfg_write(CfgStartupOn, v);
      cfg_write(CfgAutoOffMin, run_cfg[p][1]);
      v = {7'($urandom), run_cfg[p][2][0]};
      cfg_write(CfgInitialAuto, v);
      v = {7'($urandom), run_cfg[p][3][0]};
      cfg_write(CfgSensorPresent, v);
      tick_share = $urandom_range(55, 85);
      for (int i = 0; i < ItemsPerRun; i++) begin
        if (i % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
        next_random_item(it);
        send_item(it, 1'b0, typed_res);
      end
      no_idle = 1'b0;
      drain();
    end
    repeat (8) @(posedge clk_i);

    $display("sent %0d beats (%0d directed, %0d ticks, %0d of them refreshing the duty)",
             items_sent, NumRows, ticks_sent, refreshes);
    $display("checked %0d result beats across %0d register writes, %0d mismatches",
             results_seen, cfg_writes, mismatches);
    if (mismatches == 0 && dim_out_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
sv/bdab_pkg.sv
sv/bdab_in_if.sv
sv/bdab_out_if.sv
sv/bdab_core.sv
sv/backlight_dimmer_auto_brightness_unit.sv
sv/bdab_chk.sv
sim/tb.sv
